@@ design/whtt_pkg.sv @@
// Shared types, constants and the CORDIC gain function for the wrapped
// heading unit. No dependencies.
`timescale 1ns / 1ps

package whtt_pkg;

    localparam int PW = 16;
    localparam int DW = PW + 2;
    localparam int FRAC = 14;
    localparam int XW = DW + FRAC + 2;
    localparam int CW = 32;
    localparam int OW = 16;
    localparam int CFG_IDX_W = 2;
    localparam int CORDIC_STAGES_DEF = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_WORLD_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WORLD_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_DISTANCE = 2'd2;

    localparam logic [PW-1:0] WORLD_WIDTH_RST  = 16'd20480;
    localparam logic [PW-1:0] WORLD_HEIGHT_RST = 16'd11520;
    localparam logic [PW-1:0] MIN_DISTANCE_RST = 16'd160;

    localparam logic signed [OW-1:0] Q14_ONE = 16'sd16384;

    typedef struct packed {
        logic [PW-1:0] world_width;
        logic [PW-1:0] world_height;
        logic [PW-1:0] min_distance;
    } t_cfg;

    typedef struct packed {
        logic [PW-1:0] own_x;
        logic [PW-1:0] own_y;
        logic [PW-1:0] target_x;
        logic [PW-1:0] target_y;
    } t_pos;

    typedef struct packed {
        logic signed [DW-1:0] dx;
        logic signed [DW-1:0] dy;
    } t_vec;

    typedef struct packed {
        t_vec vec;
        logic too_close;
        logic is_zero;
    } t_rng;

    // Product of 1/sqrt(1+4^-i) over the stages, returned in Q28.
    // Evaluated only while elaborating; the quotients use long division.
    function automatic logic [CW-1:0] cordic_gain_q28(input int stages);
        logic [63:0] p;
        logic [63:0] den;
        logic [63:0] quo;
        logic [63:0] rem;
        logic [63:0] v;
        logic [63:0] r;
        logic [63:0] b;
        int i;
        int j;
        int k;
        p = 64'd1 << 62;
        for (i = 0; i < 24; i++) begin
            if (i < stages) begin
                den = (64'd1 << (2 * i)) + 64'd1;
                quo = 64'd0;
                rem = 64'd0;
                for (j = 63; j >= 0; j--) begin
                    rem = {rem[62:0], p[j]};
                    if (rem >= den) begin
                        rem = rem - den;
                        quo[j] = 1'b1;
                    end
                end
                p = p - quo;
            end
        end
        v = p;
        r = 64'd0;
        b = 64'd1 << 62;
        for (k = 0; k < 32; k++) begin
            if (b > v) begin
                b = b >> 2;
            end
        end
        for (k = 0; k < 32; k++) begin
            if (b != 64'd0) begin
                if (v >= r + b) begin
                    v = v - (r + b);
                    r = (r >> 1) + b;
                end else begin
                    r = r >> 1;
                end
                b = b >> 2;
            end
        end
        return r[CW+2:3];
    endfunction

endpackage

@@ design/whtt_wrap.sv @@
// Two-stage front end: per-axis difference, then wrap onto the shortest
// torus vector. Depends on whtt_pkg.
`timescale 1ns / 1ps

module whtt_wrap import whtt_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_cfg i_cfg,
    input  logic i_valid,
    output logic o_ready,
    input  t_pos i_pos,
    output logic o_valid,
    input  logic i_ready,
    output t_vec o_vec
);

    function automatic logic signed [DW-1:0] wrap_axis(
        input logic signed [DW-1:0] d,
        input logic [PW-1:0] size
    );
        logic signed [DW:0] d2;
        logic signed [DW:0] sz;
        logic signed [DW-1:0] szd;
        d2 = {d, 1'b0};
        sz = $signed({3'b000, size});
        szd = $signed({2'b00, size});
        if (d2 > sz) begin
            wrap_axis = d - szd;
        end else if (d2 < -sz) begin
            wrap_axis = d + szd;
        end else begin
            wrap_axis = d;
        end
    endfunction

    logic r_v1;
    logic r_v2;
    logic w_rdy1;
    logic w_rdy2;
    logic signed [DW-1:0] r_dx_raw;
    logic signed [DW-1:0] r_dy_raw;
    logic signed [DW-1:0] n_dx_raw;
    logic signed [DW-1:0] n_dy_raw;
    t_vec r_vec;
    t_vec n_vec;

    assign w_rdy2 = !r_v2 || i_ready;
    assign w_rdy1 = !r_v1 || w_rdy2;
    assign o_ready = w_rdy1;
    assign o_valid = r_v2;
    assign o_vec = r_vec;

    assign n_dx_raw = $signed({2'b00, i_pos.target_x}) - $signed({2'b00, i_pos.own_x});
    assign n_dy_raw = $signed({2'b00, i_pos.target_y}) - $signed({2'b00, i_pos.own_y});
    assign n_vec.dx = wrap_axis(r_dx_raw, i_cfg.world_width);
    assign n_vec.dy = wrap_axis(r_dy_raw, i_cfg.world_height);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (w_rdy1) begin
                r_v1 <= i_valid;
            end
            if (w_rdy2) begin
                r_v2 <= r_v1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy1 && i_valid) begin
            r_dx_raw <= n_dx_raw;
            r_dy_raw <= n_dy_raw;
        end
        if (w_rdy2 && r_v1) begin
            r_vec <= n_vec;
        end
    end

endmodule

@@ design/whtt_range.sv @@
// Two-stage distance test: squares in the first stage, sum and compare
// against the squared minimum distance in the second. Depends on whtt_pkg.
`timescale 1ns / 1ps

module whtt_range import whtt_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic [PW-1:0] i_min_distance,
    input  logic i_valid,
    output logic o_ready,
    input  t_vec i_vec,
    output logic o_valid,
    input  logic i_ready,
    output t_rng o_rng
);

    logic r_v1;
    logic r_v2;
    logic w_rdy1;
    logic w_rdy2;
    logic signed [2*DW-1:0] w_px;
    logic signed [2*DW-1:0] w_py;
    logic [2*PW:0] r_sq_x;
    logic [2*PW:0] r_sq_y;
    logic [2*PW-1:0] r_md_sq;
    t_vec r_vec;
    logic [2*PW+1:0] w_sum;
    t_rng n_rng;
    t_rng r_rng;

    assign w_rdy2 = !r_v2 || i_ready;
    assign w_rdy1 = !r_v1 || w_rdy2;
    assign o_ready = w_rdy1;
    assign o_valid = r_v2;
    assign o_rng = r_rng;

    assign w_px = i_vec.dx * i_vec.dx;
    assign w_py = i_vec.dy * i_vec.dy;

    assign w_sum = {1'b0, r_sq_x} + {1'b0, r_sq_y};
    assign n_rng.vec = r_vec;
    assign n_rng.too_close = w_sum < {2'b00, r_md_sq};
    assign n_rng.is_zero = (r_vec.dx == '0) && (r_vec.dy == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (w_rdy1) begin
                r_v1 <= i_valid;
            end
            if (w_rdy2) begin
                r_v2 <= r_v1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy1 && i_valid) begin
            r_sq_x <= w_px[2*PW:0];
            r_sq_y <= w_py[2*PW:0];
            r_md_sq <= {{PW{1'b0}}, i_min_distance} * {{PW{1'b0}}, i_min_distance};
            r_vec <= i_vec;
        end
        if (w_rdy2 && r_v1) begin
            r_rng <= n_rng;
        end
    end

endmodule

@@ design/whtt_cordic.sv @@
// Pipelined CORDIC: one setup stage, one rotation per stage, and a rounding
// stage that also applies the special cases. Depends on whtt_pkg.
`timescale 1ns / 1ps

module whtt_cordic import whtt_pkg::*; #(
    parameter int STAGES = CORDIC_STAGES_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_rng i_rng,
    output logic o_valid,
    input  logic i_ready,
    output logic signed [OW-1:0] o_cos,
    output logic signed [OW-1:0] o_sin,
    output logic o_updated
);

    localparam logic signed [CW-1:0] K_Q28 = $signed(cordic_gain_q28(STAGES));
    localparam int LAST = STAGES + 1;

    typedef struct packed {
        logic flip;
        logic too_close;
        logic is_zero;
    } t_ctl;

    function automatic logic signed [OW-1:0] to_q14(input logic signed [CW-1:0] v);
        logic signed [CW:0] t;
        logic signed [CW-FRAC:0] q;
        t = {v[CW-1], v} + (CW+1)'(1 << (FRAC - 1));
        q = (CW-FRAC+1)'(t >>> FRAC);
        if (q > (CW-FRAC+1)'(Q14_ONE)) begin
            to_q14 = Q14_ONE;
        end else if (q < -(CW-FRAC+1)'(Q14_ONE)) begin
            to_q14 = -Q14_ONE;
        end else begin
            to_q14 = q[OW-1:0];
        end
    endfunction

    logic [LAST:0] r_v;
    logic [LAST:0] w_vin;
    logic [LAST+1:0] w_rdy;
    logic signed [XW-1:0] r_x [0:STAGES];
    logic signed [XW-1:0] r_y [0:STAGES];
    logic signed [CW-1:0] r_c [0:STAGES];
    logic signed [CW-1:0] r_s [0:STAGES];
    t_ctl r_ctl [0:STAGES];

    logic signed [DW-1:0] w_x0;
    logic signed [DW-1:0] w_y0;
    t_ctl n_ctl0;
    logic signed [OW-1:0] w_cq;
    logic signed [OW-1:0] w_sq;
    logic signed [OW-1:0] n_cos;
    logic signed [OW-1:0] n_sin;
    logic n_upd;
    logic signed [OW-1:0] r_cos;
    logic signed [OW-1:0] r_sin;
    logic r_upd;

    assign w_vin = {r_v[LAST-1:0], i_valid};
    assign w_rdy[LAST+1] = i_ready;
    assign o_ready = w_rdy[0];
    assign o_valid = r_v[LAST];
    assign o_cos = r_cos;
    assign o_sin = r_sin;
    assign o_updated = r_upd;

    for (genvar k = 0; k <= LAST; k++) begin : g_rdy
        assign w_rdy[k] = !r_v[k] || w_rdy[k+1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            for (int k = 0; k <= LAST; k++) begin
                if (w_rdy[k]) begin
                    r_v[k] <= w_vin[k];
                end
            end
        end
    end

    assign n_ctl0.flip = i_rng.vec.dy < 0;
    assign n_ctl0.too_close = i_rng.too_close;
    assign n_ctl0.is_zero = i_rng.is_zero;
    assign w_x0 = n_ctl0.flip ? -i_rng.vec.dy : i_rng.vec.dy;
    assign w_y0 = n_ctl0.flip ? -i_rng.vec.dx : i_rng.vec.dx;

    always_ff @(posedge i_clk) begin
        if (w_rdy[0] && i_valid) begin
            r_x[0] <= XW'(w_x0) <<< FRAC;
            r_y[0] <= XW'(w_y0) <<< FRAC;
            r_c[0] <= K_Q28;
            r_s[0] <= '0;
            r_ctl[0] <= n_ctl0;
        end
    end

    for (genvar g = 1; g <= STAGES; g++) begin : g_rot
        logic w_dir;
        logic signed [XW-1:0] w_xs;
        logic signed [XW-1:0] w_ys;
        logic signed [CW-1:0] w_cs;
        logic signed [CW-1:0] w_ss;

        assign w_dir = !r_y[g-1][XW-1];
        assign w_xs = r_x[g-1] >>> (g - 1);
        assign w_ys = r_y[g-1] >>> (g - 1);
        assign w_cs = r_c[g-1] >>> (g - 1);
        assign w_ss = r_s[g-1] >>> (g - 1);

        always_ff @(posedge i_clk) begin
            if (w_rdy[g] && r_v[g-1]) begin
                r_x[g] <= w_dir ? r_x[g-1] + w_ys : r_x[g-1] - w_ys;
                r_y[g] <= w_dir ? r_y[g-1] - w_xs : r_y[g-1] + w_xs;
                r_c[g] <= w_dir ? r_c[g-1] - w_ss : r_c[g-1] + w_ss;
                r_s[g] <= w_dir ? r_s[g-1] + w_cs : r_s[g-1] - w_cs;
                r_ctl[g] <= r_ctl[g-1];
            end
        end
    end

    assign w_cq = to_q14(r_c[STAGES]);
    assign w_sq = to_q14(r_s[STAGES]);

    always_comb begin
        if (r_ctl[STAGES].too_close) begin
            n_cos = '0;
            n_sin = '0;
            n_upd = 1'b0;
        end else if (r_ctl[STAGES].is_zero) begin
            n_cos = Q14_ONE;
            n_sin = '0;
            n_upd = 1'b1;
        end else begin
            n_cos = r_ctl[STAGES].flip ? -w_cq : w_cq;
            n_sin = r_ctl[STAGES].flip ? -w_sq : w_sq;
            n_upd = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[LAST] && r_v[STAGES]) begin
            r_cos <= n_cos;
            r_sin <= n_sin;
            r_upd <= n_upd;
        end
    end

endmodule

@@ design/wrapped_heading_toward_target_unit.sv @@
// Top level of the wrapped heading unit: configuration registers and the
// chain wrap -> range -> CORDIC. Depends on whtt_pkg, whtt_wrap, whtt_range, whtt_cordic.
//
//   port group        dir   beat contents
//   s_axis_*          in    own_x, own_y, target_x, target_y (Q12.4)
//   m_axis_*          out   heading_cos, heading_sin (Q1.14), updated in tuser
//   i_cfg_*           in    world_width, world_height, min_distance writes
//
// One beat is accepted per cycle while the pipeline is not full and stalled;
// each CORDIC rotation has its own register stage.
// Reset clears every valid bit and loads the default world and distance.
// Each stage holds its beat while the next stage is full and stalled, so
// empty stages close up and input is taken while the output waits.
`timescale 1ns / 1ps

module wrapped_heading_toward_target_unit import whtt_pkg::*; #(
    parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [PW-1:0] i_cfg_wdata,
    input  logic s_axis_tvalid,
    output logic s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // own_x, own_y, target_x, target_y
    output logic m_axis_tvalid,
    input  logic m_axis_tready,
    output logic [31:0] m_axis_tdata,   // heading_cos, heading_sin
    output logic [0:0] m_axis_tuser     // updated
);

    t_cfg r_cfg;
    t_pos w_pos;
    t_vec w_vec;
    t_rng w_rng;
    logic w_wrap_valid;
    logic w_wrap_ready;
    logic w_rng_valid;
    logic w_rng_ready;
    logic signed [OW-1:0] w_cos;
    logic signed [OW-1:0] w_sin;
    logic w_upd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.world_width <= WORLD_WIDTH_RST;
            r_cfg.world_height <= WORLD_HEIGHT_RST;
            r_cfg.min_distance <= MIN_DISTANCE_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_WORLD_WIDTH: begin
                    r_cfg.world_width <= i_cfg_wdata;
                end
                CFG_WORLD_HEIGHT: begin
                    r_cfg.world_height <= i_cfg_wdata;
                end
                CFG_MIN_DISTANCE: begin
                    r_cfg.min_distance <= i_cfg_wdata;
                end
                default: begin
                end
            endcase
        end
    end

    assign w_pos.own_x = s_axis_tdata[15:0];
    assign w_pos.own_y = s_axis_tdata[31:16];
    assign w_pos.target_x = s_axis_tdata[47:32];
    assign w_pos.target_y = s_axis_tdata[63:48];

    whtt_wrap u_wrap (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_pos   (w_pos),
        .o_valid (w_wrap_valid),
        .i_ready (w_wrap_ready),
        .o_vec   (w_vec)
    );

    whtt_range u_range (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_min_distance (r_cfg.min_distance),
        .i_valid        (w_wrap_valid),
        .o_ready        (w_wrap_ready),
        .i_vec          (w_vec),
        .o_valid        (w_rng_valid),
        .i_ready        (w_rng_ready),
        .o_rng          (w_rng)
    );

    whtt_cordic #(
        .STAGES (CORDIC_STAGES)
    ) u_cordic (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (w_rng_valid),
        .o_ready   (w_rng_ready),
        .i_rng     (w_rng),
        .o_valid   (m_axis_tvalid),
        .i_ready   (m_axis_tready),
        .o_cos     (w_cos),
        .o_sin     (w_sin),
        .o_updated (w_upd)
    );

    assign m_axis_tdata = {w_sin, w_cos};
    assign m_axis_tuser = w_upd;

`ifndef NO_ASSERTIONS
    a_idle_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled while the output stage is empty");

    a_no_heading_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata == 32'd0)
        else $error("heading fields nonzero without an update");

    a_heading_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> $signed(m_axis_tdata[15:0]) <= Q14_ONE
            && $signed(m_axis_tdata[15:0]) >= -Q14_ONE
            && $signed(m_axis_tdata[31:16]) <= Q14_ONE
            && $signed(m_axis_tdata[31:16]) >= -Q14_ONE)
        else $error("heading component outside unit range");
`endif

endmodule
